// ----- hdl/moaep_pkg.sv -----
// Shared types and constants for the motor output arbiter and ESC programmer.
package moaep_pkg;

	localparam int MOTORS  = 4;
	localparam int VAL_W   = 11;
	localparam int CMD_W   = 6;
	localparam int DELAY_W = 16;
	localparam int REP_W   = 8;
	localparam int IN_W    = 16;

	typedef logic [VAL_W-1:0]   val_t;
	typedef logic [CMD_W-1:0]   cmd_t;
	typedef logic [DELAY_W-1:0] delay_t;
	typedef logic [REP_W-1:0]   rep_t;

	typedef enum logic [3:0] {
		OP_TICK       = 4'd0,
		OP_ARM        = 4'd1,
		OP_DISARM     = 4'd2,
		OP_CLEAR_TEST = 4'd3,
		OP_TEST       = 4'd4,
		OP_DIR_FIX    = 4'd5,
		OP_DIR        = 4'd6,
		OP_RAW        = 4'd7,
		OP_FAILSAFE   = 4'd8,
		OP_THROTTLE   = 4'd9,
		OP_RC_INPUT   = 4'd10,
		OP_CONTROL    = 4'd11,
		OP_STATUS     = 4'd12
	} opcode_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_INIT   = 3'd1,
		PH_DIR    = 3'd2,
		PH_SAVE   = 3'd3,
		PH_SDELAY = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		MODE_DISARMED = 2'd0,
		MODE_ARMED    = 2'd1,
		MODE_FAILSAFE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		KIND_THROTTLE = 2'd0,
		KIND_COMMAND  = 2'd1,
		KIND_STATUS   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		REG_THROTTLE_FLOOR   = 3'd0,
		REG_THROTTLE_CEILING = 3'd1,
		REG_TEST_LIMIT       = 3'd2,
		REG_INITIAL_WAIT     = 3'd3,
		REG_COMMAND_REPEATS  = 3'd4,
		REG_SAVE_WAIT        = 3'd5
	} reg_index_t;

	localparam cmd_t CMD_STOP = 6'd0;
	localparam cmd_t CMD_DIR1 = 6'd7;
	localparam cmd_t CMD_DIR2 = 6'd8;
	localparam cmd_t CMD_SAVE = 6'd12;
	localparam logic [IN_W-1:0] CMD_MAX = 16'd47;

	localparam val_t   RST_THROTTLE_FLOOR   = 11'd1000;
	localparam val_t   RST_THROTTLE_CEILING = 11'd2000;
	localparam val_t   RST_TEST_LIMIT       = 11'd300;
	localparam delay_t RST_INITIAL_WAIT     = 16'd500;
	localparam rep_t   RST_COMMAND_REPEATS  = 8'd10;
	localparam delay_t RST_SAVE_WAIT        = 16'd100;

	typedef struct packed {
		val_t   throttle_floor;
		val_t   throttle_ceiling;
		val_t   test_limit;
		delay_t initial_wait;
		rep_t   command_repeats;
		delay_t save_wait;
	} cfg_t;

	typedef struct packed {
		logic [3:0]                opcode;
		logic                      frame_ready;
		logic [2:0]                motor_sel;
		logic [IN_W-1:0]           value;
		logic                      flag_a;
		logic                      rc_arm;
		logic [MOTORS-1:0][VAL_W-1:0] ctl_out;
	} item_t;

	typedef struct packed {
		kind_t                        kind;
		logic [MOTORS-1:0][VAL_W-1:0] outs;
		mode_t                        arm_status;
		val_t                         rc_throttle;
	} result_t;

endpackage

// ----- hdl/moaep_cfg_regs.sv -----
// Configuration register file for clamp limits, test limit and programming timing.
module moaep_cfg_regs import moaep_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.throttle_floor   <= RST_THROTTLE_FLOOR;
			cfg_q.throttle_ceiling <= RST_THROTTLE_CEILING;
			cfg_q.test_limit       <= RST_TEST_LIMIT;
			cfg_q.initial_wait     <= RST_INITIAL_WAIT;
			cfg_q.command_repeats  <= RST_COMMAND_REPEATS;
			cfg_q.save_wait        <= RST_SAVE_WAIT;
		end else if (cfg_valid) begin
			case (reg_index_t'(cfg_index))
				REG_THROTTLE_FLOOR:   cfg_q.throttle_floor   <= cfg_data[VAL_W-1:0];
				REG_THROTTLE_CEILING: cfg_q.throttle_ceiling <= cfg_data[VAL_W-1:0];
				REG_TEST_LIMIT:       cfg_q.test_limit       <= cfg_data[VAL_W-1:0];
				REG_INITIAL_WAIT:     cfg_q.initial_wait     <= cfg_data[DELAY_W-1:0];
				REG_COMMAND_REPEATS:  cfg_q.command_repeats  <= cfg_data[REP_W-1:0];
				REG_SAVE_WAIT:        cfg_q.save_wait        <= cfg_data[DELAY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/moaep_ctrl.sv -----
// Event decoder, arming/test/programming state and frame selection.
module moaep_ctrl import moaep_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	input  cfg_t    cfg,
	output logic    res_valid,
	output result_t result
);

	mode_t                        arm_q, arm_d;
	val_t                         rc_q, rc_d;
	logic                         test_active_q, test_active_d;
	logic [MOTORS-1:0][VAL_W-1:0] test_vals_q, test_vals_d;
	phase_t                       phase_q, phase_d;
	delay_t                       delay_q, delay_d;
	rep_t                         repeat_q, repeat_d;
	logic [MOTORS-1:0][CMD_W-1:0] dir_cmds_q, dir_cmds_d;
	logic [MOTORS-1:0][CMD_W-1:0] save_cmds_q, save_cmds_d;
	logic                         ctl_active_q, ctl_active_d;
	logic [MOTORS-1:0][VAL_W-1:0] ctl_vals_q, ctl_vals_d;
	logic [MOTORS-1:0][VAL_W-1:0] last_q, last_d;

	kind_t kind;
	rep_t  rep_dec;
	val_t  rc_clamped;
	val_t  test_sat;
	logic  idx_ok;
	logic  [1:0] idx;
	logic  start_prog;

	// A floor above the ceiling still gives the floor for low values and the ceiling otherwise.
	always_comb begin
		if (item.value < {{(IN_W-VAL_W){1'b0}}, cfg.throttle_floor}) begin
			rc_clamped = cfg.throttle_floor;
		end else if (item.value > {{(IN_W-VAL_W){1'b0}}, cfg.throttle_ceiling}) begin
			rc_clamped = cfg.throttle_ceiling;
		end else begin
			rc_clamped = item.value[VAL_W-1:0];
		end
		if (item.value > {{(IN_W-VAL_W){1'b0}}, cfg.test_limit}) begin
			test_sat = cfg.test_limit;
		end else begin
			test_sat = item.value[VAL_W-1:0];
		end
	end

	assign idx_ok  = ~item.motor_sel[2];
	assign idx     = item.motor_sel[1:0];
	assign rep_dec = (repeat_q == '0) ? '0 : repeat_q - 1'b1;

	always_comb begin
		arm_d         = arm_q;
		rc_d          = rc_q;
		test_active_d = test_active_q;
		test_vals_d   = test_vals_q;
		phase_d       = phase_q;
		delay_d       = delay_q;
		repeat_d      = repeat_q;
		dir_cmds_d    = dir_cmds_q;
		save_cmds_d   = save_cmds_q;
		ctl_active_d  = ctl_active_q;
		ctl_vals_d    = ctl_vals_q;
		last_d        = last_q;
		kind          = KIND_THROTTLE;
		res_valid     = 1'b0;
		start_prog    = 1'b0;

		if (fire) begin
			case (opcode_t'(item.opcode))
				OP_TICK: begin
					if (item.frame_ready) begin
						res_valid = 1'b1;
						last_d    = '0;
						case (phase_q)
							PH_IDLE: begin
								if (test_active_q) begin
									last_d = test_vals_q;
								end else if (arm_q == MODE_ARMED && ctl_active_q) begin
									last_d = ctl_vals_q;
								end
							end
							PH_INIT: begin
								if (delay_q != '0) begin
									delay_d = delay_q - 1'b1;
								end else begin
									phase_d  = PH_DIR;
									repeat_d = cfg.command_repeats;
								end
							end
							PH_DIR: begin
								kind = KIND_COMMAND;
								for (int i = 0; i < MOTORS; i++) begin
									last_d[i] = {{(VAL_W-CMD_W){1'b0}}, dir_cmds_q[i]};
								end
								if (rep_dec == '0) begin
									phase_d  = PH_SAVE;
									repeat_d = cfg.command_repeats;
								end else begin
									repeat_d = rep_dec;
								end
							end
							PH_SAVE: begin
								kind = KIND_COMMAND;
								for (int i = 0; i < MOTORS; i++) begin
									last_d[i] = {{(VAL_W-CMD_W){1'b0}}, save_cmds_q[i]};
								end
								if (rep_dec == '0) begin
									phase_d  = PH_SDELAY;
									repeat_d = '0;
									delay_d  = cfg.save_wait;
								end else begin
									repeat_d = rep_dec;
								end
							end
							PH_SDELAY: begin
								if (delay_q != '0) begin
									delay_d = delay_q - 1'b1;
								end else begin
									phase_d     = PH_IDLE;
									delay_d     = '0;
									repeat_d    = '0;
									dir_cmds_d  = '0;
									save_cmds_d = '0;
								end
							end
							default: begin
								phase_d = PH_IDLE;
							end
						endcase
					end
				end
				OP_ARM: begin
					arm_d = MODE_ARMED;
					rc_d  = cfg.throttle_floor;
				end
				OP_DISARM: begin
					arm_d         = MODE_DISARMED;
					rc_d          = cfg.throttle_floor;
					test_active_d = 1'b0;
					test_vals_d   = '0;
					phase_d       = PH_IDLE;
					delay_d       = '0;
					repeat_d      = '0;
					dir_cmds_d    = '0;
					save_cmds_d   = '0;
					ctl_active_d  = 1'b0;
					ctl_vals_d    = '0;
					last_d        = '0;
				end
				OP_CLEAR_TEST: begin
					test_active_d = 1'b0;
					test_vals_d   = '0;
					phase_d       = PH_IDLE;
					delay_d       = '0;
					repeat_d      = '0;
					dir_cmds_d    = '0;
					save_cmds_d   = '0;
				end
				OP_TEST: begin
					if (idx_ok) begin
						test_vals_d      = '0;
						test_vals_d[idx] = test_sat;
						test_active_d    = 1'b1;
					end
				end
				OP_DIR_FIX: begin
					dir_cmds_d  = {CMD_DIR1, CMD_DIR2, CMD_DIR2, CMD_DIR2};
					save_cmds_d = {MOTORS{CMD_SAVE}};
					start_prog  = 1'b1;
				end
				OP_DIR: begin
					if (idx_ok) begin
						dir_cmds_d       = '0;
						save_cmds_d      = '0;
						dir_cmds_d[idx]  = item.flag_a ? CMD_DIR2 : CMD_DIR1;
						save_cmds_d[idx] = CMD_SAVE;
						start_prog       = 1'b1;
					end
				end
				OP_RAW: begin
					if (idx_ok && item.value <= CMD_MAX) begin
						dir_cmds_d       = '0;
						save_cmds_d      = '0;
						dir_cmds_d[idx]  = item.value[CMD_W-1:0];
						save_cmds_d[idx] = item.flag_a ? CMD_SAVE : CMD_STOP;
						start_prog       = 1'b1;
					end
				end
				OP_FAILSAFE: begin
					if (item.flag_a) begin
						arm_d = MODE_FAILSAFE;
					end else if (arm_q == MODE_FAILSAFE) begin
						arm_d = MODE_DISARMED;
					end
				end
				OP_THROTTLE: begin
					rc_d = rc_clamped;
				end
				OP_RC_INPUT: begin
					rc_d = rc_clamped;
					if (item.flag_a) begin
						arm_d = MODE_FAILSAFE;
					end else if (!item.rc_arm) begin
						arm_d = MODE_DISARMED;
					end else begin
						arm_d = MODE_ARMED;
					end
				end
				OP_CONTROL: begin
					ctl_active_d = item.flag_a;
					ctl_vals_d   = item.flag_a ? item.ctl_out : '0;
				end
				OP_STATUS: begin
					res_valid = 1'b1;
					kind      = KIND_STATUS;
				end
				default: begin
				end
			endcase

			// Every way into the programming sequence leaves the motors stopped and disarmed.
			if (start_prog) begin
				arm_d         = MODE_DISARMED;
				rc_d          = cfg.throttle_floor;
				test_active_d = 1'b0;
				test_vals_d   = '0;
				last_d        = '0;
				phase_d       = PH_INIT;
				delay_d       = cfg.initial_wait;
				repeat_d      = '0;
			end
		end

		result.kind        = kind;
		result.outs        = last_d;
		result.arm_status  = arm_d;
		result.rc_throttle = rc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_q         <= MODE_DISARMED;
			rc_q          <= RST_THROTTLE_FLOOR;
			test_active_q <= 1'b0;
			test_vals_q   <= '0;
			phase_q       <= PH_IDLE;
			delay_q       <= '0;
			repeat_q      <= '0;
			dir_cmds_q    <= '0;
			save_cmds_q   <= '0;
			ctl_active_q  <= 1'b0;
			ctl_vals_q    <= '0;
			last_q        <= '0;
		end else begin
			arm_q         <= arm_d;
			rc_q          <= rc_d;
			test_active_q <= test_active_d;
			test_vals_q   <= test_vals_d;
			phase_q       <= phase_d;
			delay_q       <= delay_d;
			repeat_q      <= repeat_d;
			dir_cmds_q    <= dir_cmds_d;
			save_cmds_q   <= save_cmds_d;
			ctl_active_q  <= ctl_active_d;
			ctl_vals_q    <= ctl_vals_d;
			last_q        <= last_d;
		end
	end

	// The sequencer only returns to idle through a full clear of its counters.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (delay_q == '0 && repeat_q == '0))
		else $error("idle programming phase with live counters");

	// A valid motor test transaction always enables test output.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.opcode == OP_TEST && !item.motor_sel[2]) |=> test_active_q)
		else $error("motor test not activated");

endmodule

// ----- hdl/motor_output_arbiter_esc_programmer_core.sv -----
// Top level: input register, control logic and output register of the motor output arbiter.
//
// Channel   Dir  Handshake             Payload
// s_*       in   s_tvalid / s_tready   s_tuser opcode, s_tdata event fields
// m_*       out  m_tvalid / m_tready   m_tuser frame kind, m_tdata frame and status
// cfg_*     in   cfg_valid / cfg_ready cfg_index register, cfg_data value
//
// One transaction is accepted per cycle unless the output stalls; it sits in the input register,
// then the state update writes its result, if it has one, to the output register.
// Throughput is one event per cycle while the output is not stalled.
// Reset clears all but the data registers at once, with no sweep; cfg_ready is always high.
// A stalled output holds the input register, and s_tready drops only when both are full.
module motor_output_arbiter_esc_programmer_core import moaep_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // frame_ready, motor_sel[2:0], value[15:0], flag_a,
	                              // rc_arm, ctl_out0..ctl_out3 [10:0], zero pad
	input  logic [3:0]  s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // out0..out3 [10:0], arm_status[1:0],
	                              // rc_throttle_now[10:0], zero pad
	output logic [1:0]  m_tuser,  // kind
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t    cfg;
	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	logic    fire;
	logic    res_valid;
	result_t result;
	result_t result_s2;
	logic    valid_s2;

	assign cfg_ready = 1'b1;

	moaep_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	always_comb begin
		item_in.opcode      = s_tuser;
		item_in.frame_ready = s_tdata[0];
		item_in.motor_sel   = s_tdata[3:1];
		item_in.value       = s_tdata[19:4];
		item_in.flag_a      = s_tdata[20];
		item_in.rc_arm      = s_tdata[21];
		for (int i = 0; i < MOTORS; i++) begin
			item_in.ctl_out[i] = s_tdata[22 + VAL_W*i +: VAL_W];
		end
	end

	assign advance  = !valid_s2 || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			item_s1 <= item_in;
		end
	end

	moaep_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = result_s2.kind;
	assign m_tdata  = {7'b0, result_s2.rc_throttle, result_s2.arm_status, result_s2.outs};

	// A held input register keeps its transaction until the output side frees up.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("input register lost a stalled transaction");

	// A new result only appears after an event was processed.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid ##1 m_tvalid) |-> $past(fire))
		else $error("result appeared without a processed event");

endmodule
